@@ rtl/core/latency_decade_histogram_assert.svh @@
// assertion macros used by the latency histogram checker
// no dependencies; each macro samples on i_clk and is disabled while i_rst_n is low
`ifndef LATENCY_DECADE_HISTOGRAM_ASSERT_SVH
`define LATENCY_DECADE_HISTOGRAM_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define LDH_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define LDH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/ldh_pkg.sv @@
// shared types, codes and constants of the latency decade histogram
// no dependencies
`default_nettype none

package ldh_pkg;

    localparam int LAT_W       = 48;
    localparam int VAL_W       = 64;
    localparam int SUM_W       = 64;
    localparam int NUM_BUCKETS = 7;
    localparam int BKT_W       = 3;
    localparam int TYPE_SEL_W  = 3;
    localparam int STAT_W      = 4;

    localparam logic [LAT_W-1:0] MIN_PRESET = 48'h0000_FFFF_FFFF;
    localparam logic [VAL_W-1:0] US_DIV     = 64'd1000;

    localparam logic [LAT_W-1:0] DECADE_LIMIT [NUM_BUCKETS-1] = '{
        48'd100, 48'd1000, 48'd10000, 48'd100000, 48'd1000000, 48'd10000000
    };

    typedef enum logic [1:0] {
        OP_ENABLE  = 2'd0,
        OP_DISABLE = 2'd1,
        OP_RECORD  = 2'd2,
        OP_READ    = 2'd3
    } t_op;

    localparam logic [STAT_W-1:0] STAT_BKT_FIRST = 4'd0;
    localparam logic [STAT_W-1:0] STAT_BKT_LAST  = 4'd6;
    localparam logic [STAT_W-1:0] STAT_MIN       = 4'd7;
    localparam logic [STAT_W-1:0] STAT_MAX       = 4'd8;
    localparam logic [STAT_W-1:0] STAT_AVG       = 4'd9;

    typedef struct packed {
        logic                  enable;
        logic                  clear;
        logic                  record;
        logic [TYPE_SEL_W-1:0] type_sel;
        logic [STAT_W-1:0]     stat_sel;
        logic [LAT_W-1:0]      lat;
    } t_store_cmd;

    typedef struct packed {
        logic             enabled;
        logic [VAL_W-1:0] bucket;
        logic [LAT_W-1:0] min_lat;
        logic [LAT_W-1:0] max_lat;
        logic [SUM_W-1:0] sum;
        logic [VAL_W-1:0] count;
    } t_stat_view;

    // limits rise monotonically, so the last one passed gives the bucket
    function automatic logic [BKT_W-1:0] bucket_of(input logic [LAT_W-1:0] lat);
        logic [BKT_W-1:0] b;
        b = '0;
        for (int i = 0; i < NUM_BUCKETS - 1; i++) begin
            if (lat >= DECADE_LIMIT[i]) begin
                b = BKT_W'(i + 1);
            end
        end
        return b;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/ldh_stat_store.sv @@
// per-type statistics registers: enable flags, decade buckets, min, max, sum, count
// depends on ldh_pkg
`default_nettype none

module ldh_stat_store #(
    parameter int NUM_TYPES   = 3,
    parameter int COUNT_WIDTH = 32
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  ldh_pkg::t_store_cmd i_cmd,
    output ldh_pkg::t_stat_view o_view
);
    import ldh_pkg::*;

    localparam int TW = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;

    logic                   r_en     [NUM_TYPES];
    logic [COUNT_WIDTH-1:0] r_bucket [NUM_TYPES][NUM_BUCKETS];
    logic [LAT_W-1:0]       r_min    [NUM_TYPES];
    logic [LAT_W-1:0]       r_max    [NUM_TYPES];
    logic [SUM_W-1:0]       r_sum    [NUM_TYPES];
    logic [COUNT_WIDTH-1:0] r_cnt    [NUM_TYPES];

    logic [TW-1:0]    w_t;
    logic [BKT_W-1:0] w_bkt;
    logic [BKT_W-1:0] w_rsel;

    assign w_t    = i_cmd.type_sel[TW-1:0];
    assign w_bkt  = bucket_of(i_cmd.lat);
    assign w_rsel = i_cmd.stat_sel[BKT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < NUM_TYPES; t++) begin
                r_en[t]  <= 1'b0;
                r_min[t] <= '0;
                r_max[t] <= '0;
                r_sum[t] <= '0;
                r_cnt[t] <= '0;
                for (int b = 0; b < NUM_BUCKETS; b++) begin
                    r_bucket[t][b] <= '0;
                end
            end
        end else if (i_cmd.enable && !r_en[w_t]) begin
            r_en[w_t]  <= 1'b1;
            r_min[w_t] <= MIN_PRESET;
        end else if (i_cmd.clear && r_en[w_t]) begin
            r_en[w_t]  <= 1'b0;
            r_min[w_t] <= '0;
            r_max[w_t] <= '0;
            r_sum[w_t] <= '0;
            r_cnt[w_t] <= '0;
            for (int b = 0; b < NUM_BUCKETS; b++) begin
                r_bucket[w_t][b] <= '0;
            end
        end else if (i_cmd.record && r_en[w_t]) begin
            r_bucket[w_t][w_bkt] <= COUNT_WIDTH'(r_bucket[w_t][w_bkt] + 1'b1);
            if (i_cmd.lat < r_min[w_t]) begin
                r_min[w_t] <= i_cmd.lat;
            end
            if (i_cmd.lat > r_max[w_t]) begin
                r_max[w_t] <= i_cmd.lat;
            end
            r_sum[w_t] <= r_sum[w_t] + SUM_W'(i_cmd.lat);
            r_cnt[w_t] <= COUNT_WIDTH'(r_cnt[w_t] + 1'b1);
        end
    end

    always_comb begin
        o_view.enabled = r_en[w_t];
        o_view.bucket  = (i_cmd.stat_sel <= STAT_BKT_LAST) ?
                         VAL_W'(r_bucket[w_t][w_rsel]) : '0;
        o_view.min_lat = r_min[w_t];
        o_view.max_lat = r_max[w_t];
        o_view.sum     = r_sum[w_t];
        o_view.count   = VAL_W'(r_cnt[w_t]);
    end

endmodule

`default_nettype wire

@@ rtl/core/ldh_serial_div.sv @@
// restoring divider, one quotient bit per cycle through a shift register
// depends on ldh_pkg
`default_nettype none

module ldh_serial_div (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_start,
    input  wire  [ldh_pkg::VAL_W-1:0] i_num,
    input  wire  [ldh_pkg::VAL_W-1:0] i_den,
    output logic                     o_done,
    output logic [ldh_pkg::VAL_W-1:0] o_quo
);
    import ldh_pkg::*;

    localparam int CW = $clog2(VAL_W);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_step;
    logic [VAL_W-1:0] r_quo;
    logic [VAL_W-1:0] r_rem;
    logic [VAL_W-1:0] r_den;

    logic [VAL_W:0]   w_shift;
    logic             w_fits;

    // partial remainder with the next dividend bit shifted in
    assign w_shift = {r_rem, r_quo[VAL_W-1]};
    assign w_fits  = (w_shift >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= r_busy && (r_step == CW'(VAL_W - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= CW'(r_step + 1'b1);
                if (r_step == CW'(VAL_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[VAL_W-2:0], w_fits};
            r_rem <= w_fits ? VAL_W'(w_shift - {1'b0, r_den}) : w_shift[VAL_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

@@ rtl/core/latency_decade_histogram.sv @@
// latency decade histogram, top level: input capture, sequencer, result register
// depends on ldh_pkg, ldh_stat_store, ldh_serial_div
//
// input channel: i_valid / o_stall carry one word (op, type, latency, stat);
// a word is taken at an edge with i_valid high and o_stall low
// output channel: o_valid / i_stall carry one result word per input word
// (read value, enable flag of the addressed type after the word)
// enable, disable, record and bucket reads: capture, execute against
// the statistics registers, result load
// min, max and average reads add the 64-step bit-serial divider between
// execute and result load (skipped for a min at its preset or an average
// with no samples); the divider turns nanoseconds into microseconds and
// the sum into an average
// a word's result shows on o_valid once the result register is loaded;
// o_stall is high for the whole time a word is in work
// the result register frees the sequencer, so the next word is taken
// while a result still waits on a stalled receiver; a result held by
// i_stall keeps its value until taken
// synchronous reset (i_rst_n low) clears all statistics and enable flags
// and drops any word in work and any pending result
`default_nettype none

module latency_decade_histogram #(
    parameter int NUM_TYPES   = 3,
    parameter int COUNT_WIDTH = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [1:0]  i_op,
    input  wire  [1:0]  i_type_index,
    input  wire  [47:0] i_latency_ns,
    input  wire  [3:0]  i_stat_index,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [63:0] o_read_value,
    output logic        o_type_enabled
);
    import ldh_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state                r_state, n_state;
    t_op                   r_op;
    logic [TYPE_SEL_W-1:0] r_type;
    logic                  r_in_range;
    logic [LAT_W-1:0]      r_lat;
    logic [STAT_W-1:0]     r_stat;
    logic [VAL_W-1:0]      r_value, n_value;
    logic                  r_out_valid;
    logic [VAL_W-1:0]      r_out_value;
    logic                  r_out_en;

    t_store_cmd            w_cmd;
    t_stat_view            w_view;
    logic [VAL_W-1:0]      w_avg_den;
    logic                  w_div_start;
    logic [VAL_W-1:0]      w_div_num;
    logic [VAL_W-1:0]      w_div_den;
    logic                  w_div_done;
    logic [VAL_W-1:0]      w_div_quo;
    logic                  w_accept;
    logic                  w_out_free;
    logic                  w_in_range;

    assign w_accept   = (r_state == S_IDLE) && i_valid;
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_in_range = (4'(i_type_index) < 4'(NUM_TYPES));

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op       <= t_op'(i_op);
            r_type     <= w_in_range ? TYPE_SEL_W'(i_type_index) : '0;
            r_in_range <= w_in_range;
            r_lat      <= i_latency_ns;
            r_stat     <= i_stat_index;
        end
    end

    always_comb begin
        w_cmd.enable   = (r_state == S_EXEC) && r_in_range && (r_op == OP_ENABLE);
        w_cmd.clear    = (r_state == S_EXEC) && r_in_range && (r_op == OP_DISABLE);
        w_cmd.record   = (r_state == S_EXEC) && r_in_range && (r_op == OP_RECORD);
        w_cmd.type_sel = r_type;
        w_cmd.stat_sel = r_stat;
        w_cmd.lat      = r_lat;
    end

    ldh_stat_store #(
        .NUM_TYPES   (NUM_TYPES),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_view  (w_view)
    );

    // count * 1000 wrapping to 64 bits
    assign w_avg_den = (w_view.count << 10) - (w_view.count << 4) - (w_view.count << 3);

    always_comb begin
        n_state     = r_state;
        n_value     = r_value;
        w_div_start = 1'b0;
        w_div_num   = '0;
        w_div_den   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_value = '0;
                n_state = S_DONE;
                if (r_in_range && (r_op == OP_READ)) begin
                    case (r_stat) inside
                        [STAT_BKT_FIRST:STAT_BKT_LAST]: begin
                            n_value = w_view.bucket;
                        end
                        STAT_MIN: begin
                            // min still at its preset reads as zero
                            if (w_view.min_lat != MIN_PRESET) begin
                                w_div_start = 1'b1;
                                w_div_num   = VAL_W'(w_view.min_lat);
                                w_div_den   = US_DIV;
                                n_state     = S_DIV;
                            end
                        end
                        STAT_MAX: begin
                            w_div_start = 1'b1;
                            w_div_num   = VAL_W'(w_view.max_lat);
                            w_div_den   = US_DIV;
                            n_state     = S_DIV;
                        end
                        STAT_AVG: begin
                            if (w_avg_den != '0) begin
                                w_div_start = 1'b1;
                                w_div_num   = w_view.sum;
                                w_div_den   = w_avg_den;
                                n_state     = S_DIV;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_value = w_div_quo;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    ldh_serial_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && w_out_free) begin
            r_out_value <= r_value;
            r_out_en    <= r_in_range && w_view.enabled;
        end
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_read_value   = r_out_value;
    assign o_type_enabled = r_out_en;

endmodule

`default_nettype wire

@@ rtl/core/ldh_checker.sv @@
// port-level checks of the latency decade histogram, bound to the top level
// depends on latency_decade_histogram_assert.svh and latency_decade_histogram
`default_nettype none

`include "latency_decade_histogram_assert.svh"

module ldh_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_valid,
    input wire        o_stall,
    input wire        o_valid,
    input wire        i_stall,
    input wire [63:0] o_read_value,
    input wire        o_type_enabled
);

    // held result keeps its word while the receiver stalls
    `LDH_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_read_value) && $stable(o_type_enabled), "result changed while stalled")

    // one word in work at a time
    `LDH_ASSERT_NEXT(a_busy_after_take, i_valid && !o_stall, o_stall, "second word taken while busy")

    // a new result only comes out of a word that was in work
    `LDH_ASSERT_SAME(a_rise_from_work, $rose(o_valid), $past(o_stall), "result without a word in work")

    // no result can be produced the cycle after a word is taken
    `LDH_ASSERT_NEXT(a_no_early_result, i_valid && !o_stall, !$rose(o_valid), "result too early")

endmodule

bind latency_decade_histogram ldh_checker u_ldh_checker (.*);

`default_nettype wire

@@ verif/tb_latency_decade_histogram.sv @@
// self-checking testbench for latency_decade_histogram: directed and random words on
// the valid/stall channels, each result compared with an in-bench statistics predictor
// depends on ldh_pkg and the latency_decade_histogram rtl
`default_nettype none

module tb_latency_decade_histogram;
    timeunit 1ns;
    timeprecision 1ps;

    import ldh_pkg::*;

    localparam int NUM_TYPES = 3;
    localparam int COUNT_W   = 32;

    // codes that address nothing in the block
    localparam logic [1:0]        TYPE_NONE = 2'd3;
    localparam logic [STAT_W-1:0] STAT_NONE = 4'd15;

    localparam logic [LAT_W-1:0] LAT_TOP = 48'hFFFF_FFFF_FFFF;

    typedef struct {
        logic [VAL_W-1:0] value;
        logic             enabled;
    } t_stat_reply;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_valid;
    logic         o_stall;
    logic [1:0]   i_op;
    logic [1:0]   i_type_index;
    logic [47:0]  i_latency_ns;
    logic [3:0]   i_stat_index;
    logic         o_valid;
    logic         i_stall;
    logic [63:0]  o_read_value;
    logic         o_type_enabled;

    // predicted statistics per type
    logic               type_on    [NUM_TYPES];
    logic [COUNT_W-1:0] bucket_cnt [NUM_TYPES][NUM_BUCKETS];
    logic [LAT_W-1:0]   min_ns     [NUM_TYPES];
    logic [LAT_W-1:0]   max_ns     [NUM_TYPES];
    logic [SUM_W-1:0]   sum_ns     [NUM_TYPES];
    logic [COUNT_W-1:0] samples    [NUM_TYPES];

    t_stat_reply replies_due [$];
    int          error_count;
    int          send_idle_pct;
    int          recv_idle_pct;

    latency_decade_histogram #(
        .NUM_TYPES   (NUM_TYPES),
        .COUNT_WIDTH (COUNT_W)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_op           (i_op),
        .i_type_index   (i_type_index),
        .i_latency_ns   (i_latency_ns),
        .i_stat_index   (i_stat_index),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_read_value   (o_read_value),
        .o_type_enabled (o_type_enabled)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("tb_latency_decade_histogram: done, errors");
        $finish;
    end

    // applies one word to the predicted statistics and returns its result
    function automatic t_stat_reply predict_stat_reply(input t_op op, input logic [1:0] ti,
                                                       input logic [LAT_W-1:0] lat,
                                                       input logic [STAT_W-1:0] si);
        t_stat_reply      r;
        int               b;
        logic [VAL_W-1:0] divisor;
        r.value   = '0;
        r.enabled = 1'b0;
        if (ti >= NUM_TYPES) begin
            return r;
        end
        case (op)
            OP_ENABLE: begin
                if (!type_on[ti]) begin
                    type_on[ti] = 1'b1;
                    min_ns[ti]  = MIN_PRESET;
                end
            end
            OP_DISABLE: begin
                // clears only the addressed type
                if (type_on[ti]) begin
                    type_on[ti] = 1'b0;
                    for (int k = 0; k < NUM_BUCKETS; k++) begin
                        bucket_cnt[ti][k] = '0;
                    end
                    min_ns[ti]  = '0;
                    max_ns[ti]  = '0;
                    sum_ns[ti]  = '0;
                    samples[ti] = '0;
                end
            end
            OP_RECORD: begin
                if (type_on[ti]) begin
                    b = (lat < 48'd100)      ? 0 :
                        (lat < 48'd1000)     ? 1 :
                        (lat < 48'd10000)    ? 2 :
                        (lat < 48'd100000)   ? 3 :
                        (lat < 48'd1000000)  ? 4 :
                        (lat < 48'd10000000) ? 5 : 6;
                    bucket_cnt[ti][b] = bucket_cnt[ti][b] + 1'b1;
                    if (lat < min_ns[ti]) begin
                        min_ns[ti] = lat;
                    end
                    if (lat > max_ns[ti]) begin
                        max_ns[ti] = lat;
                    end
                    sum_ns[ti]  = sum_ns[ti] + SUM_W'(lat);
                    samples[ti] = samples[ti] + 1'b1;
                end
            end
            default: begin
                if (si <= STAT_BKT_LAST) begin
                    r.value = VAL_W'(bucket_cnt[ti][si]);
                end else if (si == STAT_MIN) begin
                    r.value = (min_ns[ti] == MIN_PRESET) ? '0 : VAL_W'(min_ns[ti] / 48'd1000);
                end else if (si == STAT_MAX) begin
                    r.value = VAL_W'(max_ns[ti] / 48'd1000);
                end else if (si == STAT_AVG) begin
                    divisor = VAL_W'(samples[ti]) * 64'd1000;
                    r.value = (divisor == '0) ? '0 : sum_ns[ti] / divisor;
                end
            end
        endcase
        r.enabled = type_on[ti];
        return r;
    endfunction

    // entered at a falling edge, returns at the falling edge after the word is taken
    task automatic send_word(input t_op op, input logic [1:0] ti,
                             input logic [LAT_W-1:0] lat, input logic [STAT_W-1:0] si);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_op         <= op;
        i_type_index <= ti;
        i_latency_ns <= lat;
        i_stat_index <= si;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        replies_due.push_back(predict_stat_reply(op, ti, lat, si));
        @(negedge i_clk);
    endtask

    // receiver stall, redrawn every cycle
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_stat_reply due;
        if (i_rst_n && o_valid && !i_stall) begin
            if (replies_due.size() == 0) begin
                $display("%0t: result word with none due: value %h enabled %b",
                         $time, o_read_value, o_type_enabled);
                error_count++;
            end else begin
                due = replies_due.pop_front();
                if (o_read_value !== due.value) begin
                    $display("%0t: read_value expected %h actual %h",
                             $time, due.value, o_read_value);
                    error_count++;
                end
                if (o_type_enabled !== due.enabled) begin
                    $display("%0t: type_enabled expected %b actual %b",
                             $time, due.enabled, o_type_enabled);
                    error_count++;
                end
            end
        end
    end

    task automatic test_after_reset;
        send_word(OP_READ, 2'd0, '0, STAT_MIN);            // disabled type reads zero
        send_word(OP_READ, TYPE_NONE, LAT_TOP, STAT_BKT_FIRST);
        send_word(OP_ENABLE, TYPE_NONE, '0, STAT_BKT_FIRST);
    endtask

    task automatic test_enable_disable;
        send_word(OP_ENABLE, 2'd0, '0, STAT_BKT_FIRST);
        send_word(OP_ENABLE, 2'd0, '0, STAT_BKT_FIRST);    // already on
        send_word(OP_READ, 2'd0, '0, STAT_MIN);            // preset reads zero
        send_word(OP_READ, 2'd0, '0, STAT_AVG);            // no samples yet
        send_word(OP_DISABLE, 2'd2, '0, STAT_BKT_FIRST);   // already off
        send_word(OP_RECORD, 2'd2, 48'd500, STAT_BKT_FIRST);
    endtask

    task automatic test_decade_limits;
        logic [LAT_W-1:0] limit_ns [7] = '{48'd0, 48'd99, 48'd100, 48'd999999,
                                           48'd1000000, 48'd10000000, LAT_TOP};
        foreach (limit_ns[k]) begin
            send_word(OP_RECORD, 2'd0, limit_ns[k], STAT_BKT_FIRST);
        end
        for (int s = STAT_BKT_FIRST; s <= STAT_AVG; s++) begin
            send_word(OP_READ, 2'd0, LAT_TOP, STAT_W'(s));
        end
        send_word(OP_READ, 2'd0, '0, STAT_NONE);
    endtask

    task automatic test_min_above_preset;
        send_word(OP_ENABLE, 2'd1, '0, STAT_BKT_FIRST);
        send_word(OP_RECORD, 2'd1, 48'h1_0000_0000, STAT_BKT_FIRST);
        send_word(OP_READ, 2'd1, '0, STAT_MIN);
        send_word(OP_READ, 2'd1, '0, STAT_MAX);
    endtask

    task automatic test_disable_own_type;
        send_word(OP_DISABLE, 2'd1, '0, STAT_BKT_FIRST);
        send_word(OP_READ, 2'd0, '0, STAT_BKT_LAST);       // neighbor keeps its counts
        send_word(OP_READ, 2'd1, '0, STAT_MAX);
        send_word(OP_READ, 2'd0, '0, STAT_MAX);
    endtask

    task automatic test_random_mix(input int n_words, input int send_pct, input int recv_pct);
        t_op               op;
        logic [1:0]        ti;
        logic [LAT_W-1:0]  lat;
        logic [STAT_W-1:0] si;
        int                pick;
        int                b;
        int unsigned       lo;
        int unsigned       hi;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int n = 0; n < n_words; n++) begin
            pick = $urandom_range(99);
            op = (pick < 10) ? OP_ENABLE : (pick < 14) ? OP_DISABLE :
                 (pick < 70) ? OP_RECORD : OP_READ;
            ti = ($urandom_range(99) < 6) ? TYPE_NONE : 2'($urandom_range(NUM_TYPES - 1));
            si = ($urandom_range(99) < 10) ? STAT_W'($urandom_range(15, 10)) :
                                             STAT_W'($urandom_range(STAT_AVG));
            pick = $urandom_range(99);
            if (pick < 55) begin
                // inside one decade, sometimes right on its bounds
                b  = $urandom_range(NUM_BUCKETS - 1);
                lo = (b == 0) ? 0 : 10 ** (b + 1);
                hi = (b == 6) ? 1_000_000_000 : 10 ** (b + 2) - 1;
                lat = LAT_W'($urandom_range(hi, lo));
                if ($urandom_range(3) == 0) begin
                    lat = $urandom_range(1) ? LAT_W'(lo) : LAT_W'(hi);
                end
            end else if (pick < 80) begin
                lat = LAT_W'({$urandom, $urandom});
            end else if (pick < 90) begin
                lat = MIN_PRESET + LAT_W'($urandom_range(2)) - 48'd1;
            end else begin
                lat = LAT_TOP - LAT_W'($urandom_range(3));
            end
            send_word(op, ti, lat, si);
        end
    endtask

    // top-value samples carry the sum far past 32 bits before the average is read
    task automatic test_large_sum;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_word(OP_DISABLE, 2'd2, '0, STAT_BKT_FIRST);
        send_word(OP_ENABLE, 2'd2, '0, STAT_BKT_FIRST);
        repeat (64) begin
            send_word(OP_RECORD, 2'd2, LAT_TOP, STAT_BKT_FIRST);
        end
        send_word(OP_READ, 2'd2, '0, STAT_AVG);
        send_word(OP_RECORD, 2'd2, 48'd0, STAT_BKT_FIRST);
        send_word(OP_READ, 2'd2, '0, STAT_AVG);
        send_word(OP_READ, 2'd2, '0, STAT_BKT_LAST);
        send_word(OP_READ, 2'd2, '0, STAT_MAX);
    endtask

    initial begin
        int waited;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_op          = OP_ENABLE;
        i_type_index  = '0;
        i_latency_ns  = '0;
        i_stat_index  = STAT_BKT_FIRST;
        error_count   = 0;
        send_idle_pct = 20;
        recv_idle_pct = 61;
        for (int t = 0; t < NUM_TYPES; t++) begin
            type_on[t] = 1'b0;
            for (int k = 0; k < NUM_BUCKETS; k++) begin
                bucket_cnt[t][k] = '0;
            end
            min_ns[t]  = '0;
            max_ns[t]  = '0;
            sum_ns[t]  = '0;
            samples[t] = '0;
        end
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_after_reset();
        test_enable_disable();
        test_decade_limits();
        test_min_above_preset();
        test_disable_own_type();
        test_random_mix(630, 20, 61);
        test_random_mix(630, 61, 20);
        test_random_mix(630, 0, 0);
        test_large_sum();
        i_valid <= 1'b0;

        waited = 0;
        while (replies_due.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (100) @(posedge i_clk);
        if (replies_due.size() != 0) begin
            $display("%0t: %0d result words never arrived", $time, replies_due.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("tb_latency_decade_histogram: done, clean");
        end else begin
            $display("tb_latency_decade_histogram: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+rtl/core
rtl/core/ldh_pkg.sv
rtl/core/ldh_stat_store.sv
rtl/core/ldh_serial_div.sv
rtl/core/latency_decade_histogram.sv
rtl/core/ldh_checker.sv
verif/tb_latency_decade_histogram.sv
